@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the scoreboard rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/phs_pkg.sv @@
// ----------------------------------------------------------------------------
// phs_pkg
// types and constants shared by the hazard scoreboard controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

  // pipeline geometry
  localparam int NUM_STAGES = 8;
  localparam int STAGE_W    = 3;
  localparam int REG_W      = 5;
  localparam int AMOUNT_W   = 8;
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 4;   // scan index can run past the last stage
  localparam int REM_W      = 3;   // bubbles still owed for one match
  localparam int NOW_W      = 4;
  localparam int OUT_CNT_W  = 32;

  localparam logic [STAGE_W-1:0] ST_IF1  = 3'd0;
  localparam logic [STAGE_W-1:0] ST_IF2  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_ID   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_EXE1 = 3'd3;
  localparam logic [STAGE_W-1:0] ST_MEM2 = 3'd6;
  localparam logic [STAGE_W-1:0] ST_WB   = 3'd7;

  // event codes
  localparam logic [CMD_W-1:0] CMD_CLOCK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STALL = 3'd4;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 296;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_op;
    logic scan_step;
    logic bubble;
    logic load_out;
  } phs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_scan;
    logic scan_end;
    logic want_bubbles;
    logic rem_last;
    logic rem_nz;
  } phs_stat_t;

endpackage

`default_nettype wire

@@ rtl/pipeline_hazard_scoreboard.sv @@
// ----------------------------------------------------------------------------
// pipeline_hazard_scoreboard
// eight-stage data hazard scoreboard with bubble insertion and hazard counters
//
//   channel  dir  ports                        content
//   in_      in   tvalid tready tdata tuser    one pipeline event
//   out_     out  tvalid tready tdata          all running counters
//
// an event is accepted, executed and its result loaded; a source check
// on a nonzero in-range register instead scans the positions exe1..mem2,
// inserting bubbles where a match needs them, and then loads its result;
// the sequencer walks the scan and shifts one bubble a cycle.
// synchronous active-low reset; slots empty, cycle counter at 7.
// a result waits in the output register while the next event is worked on;
// the block only stalls when a second result is ready and the first is held.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pipeline_hazard_scoreboard #(
  parameter int NUM_REGS     = 32,
  parameter int COUNTER_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // reg_num [4:0], need_stage [7:5], amount [15:8]
  input  wire [phs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // cmd [2:0]
  input  wire [phs_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // cycle_count [31:0], flush_count [63:32], bubble_count [95:64],
  // stall_count [127:96], hazard_count [159:128], exe1_hits [191:160],
  // exe2_hits [223:192], mem1_hits [255:224], mem2_hits [287:256],
  // bubbles_now [291:288], zero fill [295:292]
  output logic [phs_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import phs_pkg::*;

  phs_cmd_t  cmd;
  phs_stat_t stat;

  // sequencer
  phs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // slots, counters and result register
  phs_dpath #(
    .NUM_REGS     (NUM_REGS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

  // one event in flight: no new item right after an accept
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted while busy")
  // a bubble is only shifted while some are still owed
  `ASSERT_IMP(a_bubble_owed, clk, rst_n, cmd.bubble, stat.rem_nz, "bubble with none owed")
  // a result is never loaded over one that has not been taken
  `ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !out_tvalid || out_tready, "result overwritten")

endmodule

`default_nettype wire

@@ rtl/phs_ctrl.sv @@
// ----------------------------------------------------------------------------
// phs_ctrl
// event sequencer: accept, execute, source scan, bubble insertion, result
// ----------------------------------------------------------------------------
`default_nettype none

module phs_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  phs_pkg::phs_stat_t  stat,
  output phs_pkg::phs_cmd_t   cmd
);
  import phs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_BUB  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.start_scan) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.do_op = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.want_bubbles) begin
            state_nxt = S_BUB;
          end
        end
      end
      S_BUB: begin
        cmd.bubble = 1'b1;
        if (stat.rem_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/phs_dpath.sv @@
// ----------------------------------------------------------------------------
// phs_dpath
// stage slots, running counters, source scan index and result register
// ----------------------------------------------------------------------------
`default_nettype none

module phs_dpath #(
  parameter int NUM_REGS     = 32,
  parameter int COUNTER_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  phs_pkg::phs_cmd_t                   cmd,
  output phs_pkg::phs_stat_t                  stat,
  input  wire [phs_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  wire [phs_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic [phs_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import phs_pkg::*;

  localparam int CW = COUNTER_BITS;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CW-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

  // latched event
  logic [CMD_W-1:0]    cmd_r;
  logic [REG_W-1:0]    reg_r;
  logic [STAGE_W-1:0]  need_r;
  logic [AMOUNT_W-1:0] amount_r;

  // stage slots
  logic [REG_W-1:0]   dest_r  [NUM_STAGES];
  logic               valid_r [NUM_STAGES];
  logic [STAGE_W-1:0] ready_r [NUM_STAGES];

  // counters
  logic [CW-1:0] cycles_r, flushes_r, bubbles_r, stalls_r, hazards_r;
  logic [CW-1:0] hits_r [4];

  // scan state
  logic [IDX_W-1:0] idx_r;
  logic [REM_W-1:0] rem_r;
  logic             found_r;
  logic [NOW_W-1:0] now_r;

  logic [OUT_TDATA_W-1:0] out_r;

  logic                reg_ok;
  logic [STAGE_W-1:0]  slot;
  logic                match;
  logic signed [5:0]   want;
  logic                want_pos;
  logic [1:0]          hit_idx;
  logic [CW-1:0]       one_c;
  logic [CW-1:0]       two_c;
  logic [CW-1:0]       amount_c;

  assign one_c    = CW'(1);
  assign two_c    = CW'(2);
  assign amount_c = CW'(amount_r);

  // scan compare at the current index
  assign reg_ok   = (int'(reg_r) < NUM_REGS);
  assign slot     = idx_r[STAGE_W-1:0];
  assign match    = valid_r[slot] && (dest_r[slot] == reg_r);
  assign want     = $signed({3'b000, ready_r[slot]}) - $signed({3'b000, slot})
                  - $signed({3'b000, need_r}) + $signed({3'b000, ST_ID});
  assign want_pos = !want[5] && (want != 6'sd0);
  assign hit_idx  = 2'(slot - ST_EXE1);

  always_comb begin
    stat.start_scan   = (cmd_r == CMD_CHECK) && (reg_r != '0) && reg_ok;
    stat.scan_end     = (idx_r > IDX_W'(ST_MEM2));
    stat.want_bubbles = !stat.scan_end && match && want_pos;
    stat.rem_last     = (rem_r == REM_W'(1));
    stat.rem_nz       = (rem_r != '0);
  end

  // event latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      reg_r    <= in_tdata[4:0];
      need_r   <= in_tdata[7:5];
      amount_r <= in_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_CLOCK;
      idx_r   <= IDX_W'(ST_EXE1);
      rem_r   <= '0;
      found_r <= 1'b0;
      now_r   <= '0;
    end else begin
      if (cmd.load_in) begin
        cmd_r   <= in_tuser;
        idx_r   <= IDX_W'(ST_EXE1);
        rem_r   <= '0;
        found_r <= 1'b0;
        now_r   <= '0;
      end
      if (cmd.scan_step) begin
        if (match) begin
          found_r <= 1'b1;
        end
        if (match && want_pos) begin
          rem_r <= want[REM_W-1:0];
          idx_r <= idx_r + IDX_W'(want[3:0]) + IDX_W'(1);
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (cmd.bubble) begin
        rem_r <= rem_r - REM_W'(1);
        if (now_r != {NOW_W{1'b1}}) begin
          now_r <= now_r + NOW_W'(1);
        end
      end
    end
  end

  // stage slot updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        dest_r[i]  <= '0;
        valid_r[i] <= 1'b0;
        ready_r[i] <= ST_ID;
      end
    end else if (cmd.bubble) begin
      for (int i = int'(ST_WB); i > int'(ST_EXE1); i--) begin
        dest_r[i]  <= dest_r[i-1];
        valid_r[i] <= valid_r[i-1];
        ready_r[i] <= ready_r[i-1];
      end
      dest_r[ST_EXE1]  <= '0;
      valid_r[ST_EXE1] <= 1'b0;
      ready_r[ST_EXE1] <= ST_ID;
    end else if (cmd.do_op) begin
      case (cmd_r)
        CMD_CLOCK: begin
          for (int i = int'(ST_WB); i > int'(ST_IF1); i--) begin
            dest_r[i]  <= dest_r[i-1];
            valid_r[i] <= valid_r[i-1];
            ready_r[i] <= ready_r[i-1];
          end
          dest_r[ST_IF1]  <= '0;
          valid_r[ST_IF1] <= 1'b0;
          ready_r[ST_IF1] <= ST_ID;
        end
        CMD_FLUSH: begin
          // each slot from id to wb takes the slot two places before it; if1 and if2 empty
          for (int i = int'(ST_WB); i > int'(ST_IF2); i--) begin
            dest_r[i]  <= dest_r[i-2];
            valid_r[i] <= valid_r[i-2];
            ready_r[i] <= ready_r[i-2];
          end
          dest_r[ST_IF1]  <= '0;
          valid_r[ST_IF1] <= 1'b0;
          ready_r[ST_IF1] <= ST_ID;
          dest_r[ST_IF2]  <= '0;
          valid_r[ST_IF2] <= 1'b0;
          ready_r[ST_IF2] <= ST_ID;
        end
        CMD_NOTE: begin
          if (reg_ok) begin
            dest_r[ST_ID]  <= reg_r;
            valid_r[ST_ID] <= 1'b1;
            ready_r[ST_ID] <= need_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // running counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_r  <= CW'(NUM_STAGES - 1);
      flushes_r <= '0;
      bubbles_r <= '0;
      stalls_r  <= '0;
      hazards_r <= '0;
      for (int i = 0; i < 4; i++) begin
        hits_r[i] <= '0;
      end
    end else if (cmd.bubble) begin
      cycles_r  <= sat_add(cycles_r, one_c);
      bubbles_r <= sat_add(bubbles_r, one_c);
    end else if (cmd.scan_step) begin
      if (match && !found_r) begin
        hazards_r       <= sat_add(hazards_r, one_c);
        hits_r[hit_idx] <= sat_add(hits_r[hit_idx], one_c);
      end
    end else if (cmd.do_op) begin
      case (cmd_r)
        CMD_CLOCK: begin
          cycles_r <= sat_add(cycles_r, one_c);
        end
        CMD_FLUSH: begin
          flushes_r <= sat_add(flushes_r, amount_c);
          cycles_r  <= sat_add(cycles_r, two_c);
        end
        CMD_STALL: begin
          stalls_r <= sat_add(stalls_r, amount_c);
          cycles_r <= sat_add(cycles_r, amount_c);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {4'b0000, now_r,
                to_out(hits_r[3]), to_out(hits_r[2]),
                to_out(hits_r[1]), to_out(hits_r[0]),
                to_out(hazards_r), to_out(stalls_r),
                to_out(bubbles_r), to_out(flushes_r), to_out(cycles_r)};
    end
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire
